/* rtl/core/dts_pkg.sv */
// Package with the types and constants shared by the DER tag scanner modules.
package dts_pkg;

   localparam int unsigned BLEN_W = 17;
   localparam int unsigned CLEN_W = 32;
   localparam int unsigned MAX_LEN_BYTES = 4;
   localparam int unsigned MIN_ELEMENT_BYTES = 2;
   localparam logic [7:0] LONG_FORM_BIT = 8'h80;
   localparam logic [7:0] LEN_COUNT_MASK = 8'h7f;
   localparam logic [4:0] TAG_NUM_ESCAPE = 5'h1f;

   typedef enum logic [1:0] {
      PH_TAG  = 2'd0,
      PH_LEN  = 2'd1,
      PH_LENX = 2'd2,
      PH_SKIP = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_SCAN      = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOTFOUND  = 2'd2,
      ST_MALFORMED = 2'd3
   } status_type;

   typedef struct packed {
      status_type          status;
      logic [BLEN_W-1:0]   content_offset;
      logic [CLEN_W-1:0]   content_length;
   } result_type;

endpackage

/* rtl/core/dts_parser.sv */
// Scan state registers and the per-byte element walk.
module dts_parser
   import dts_pkg::*;
#(
   parameter int unsigned MAX_BUFFER_BYTES = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        target_tag,
   input  logic [7:0]        data_byte,
   input  logic              first_byte,
   input  logic [BLEN_W-1:0] buffer_length,
   output result_type        result
);

   localparam logic [24:0] MAX_BYTES = 25'(MAX_BUFFER_BYTES);

   phase_type         phase_ff, phase_in, e_phase;
   logic [BLEN_W-1:0] left_ff, left_in, e_left;
   logic [BLEN_W-1:0] pos_ff, pos_in, e_pos;
   logic [CLEN_W-1:0] acc_ff, acc_in, e_acc;
   logic [2:0]        pend_ff, pend_in, e_pend;
   logic [BLEN_W-1:0] skip_ff, skip_in, e_skip;
   logic              match_ff, match_in, e_match;
   logic              verdict_ff, verdict_in, e_verdict;

   logic [BLEN_W-1:0] sat_len;
   logic [BLEN_W-1:0] after;
   logic [BLEN_W-1:0] spare;
   logic [2:0]        len_count;
   logic [CLEN_W-1:0] clen;
   logic              header_done;

   assign sat_len = ({8'b0, buffer_length} > MAX_BYTES) ? MAX_BYTES[BLEN_W-1:0]
                                                        : buffer_length;
   assign len_count = data_byte[2:0];

   always_comb begin
      // a first byte restarts the scan from a clean state
      if (first_byte) begin
         e_phase   = PH_TAG;
         e_left    = sat_len;
         e_pos     = '0;
         e_acc     = '0;
         e_pend    = '0;
         e_skip    = '0;
         e_match   = 1'b0;
         e_verdict = 1'b0;
      end else begin
         e_phase   = phase_ff;
         e_left    = left_ff;
         e_pos     = pos_ff;
         e_acc     = acc_ff;
         e_pend    = pend_ff;
         e_skip    = skip_ff;
         e_match   = match_ff;
         e_verdict = verdict_ff;
      end

      phase_in    = e_phase;
      left_in     = e_left;
      pos_in      = e_pos;
      acc_in      = e_acc;
      pend_in     = e_pend;
      skip_in     = e_skip;
      match_in    = e_match;
      verdict_in  = e_verdict;
      result      = '{status: ST_SCAN, content_offset: '0, content_length: '0};
      after       = e_left - BLEN_W'(1);
      clen        = '0;
      header_done = 1'b0;
      spare       = '0;

      if (first_byte && (sat_len < BLEN_W'(MIN_ELEMENT_BYTES))) begin
         verdict_in    = 1'b1;
         result.status = ST_NOTFOUND;
      end else if (e_verdict) begin
         // ignore bytes until the next buffer
      end else if (e_left == '0) begin
         verdict_in    = 1'b1;
         result.status = ST_NOTFOUND;
      end else begin
         left_in = after;
         pos_in  = e_pos + BLEN_W'(1);
         case (e_phase)
            PH_TAG: begin
               if (data_byte == 8'h00) begin
                  verdict_in    = 1'b1;
                  result.status = ST_NOTFOUND;
               end else if (data_byte[4:0] == TAG_NUM_ESCAPE) begin
                  verdict_in    = 1'b1;
                  result.status = ST_MALFORMED;
               end else begin
                  match_in = (data_byte == target_tag);
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if ((data_byte & LONG_FORM_BIT) != 8'h00) begin
                  if ((data_byte & LEN_COUNT_MASK) > 8'(MAX_LEN_BYTES)) begin
                     verdict_in    = 1'b1;
                     result.status = ST_MALFORMED;
                  end else if (len_count == 3'd0) begin
                     header_done = 1'b1;
                  end else if ({14'b0, len_count} > after) begin
                     verdict_in    = 1'b1;
                     result.status = ST_NOTFOUND;
                  end else begin
                     pend_in  = len_count;
                     acc_in   = '0;
                     phase_in = PH_LENX;
                  end
               end else begin
                  clen        = {25'b0, data_byte[6:0]};
                  header_done = 1'b1;
               end
            end
            PH_LENX: begin
               acc_in  = {e_acc[CLEN_W-9:0], data_byte};
               pend_in = e_pend - 3'd1;
               if (pend_in == 3'd0) begin
                  clen        = acc_in;
                  header_done = 1'b1;
               end
            end
            PH_SKIP: begin
               skip_in = e_skip - BLEN_W'(1);
               if (skip_in == '0) begin
                  phase_in = PH_TAG;
               end
            end
            default: begin
               phase_in = PH_TAG;
            end
         endcase

         if (header_done) begin
            spare = after - clen[BLEN_W-1:0];
            if (clen > {15'b0, after}) begin
               verdict_in    = 1'b1;
               result.status = ST_NOTFOUND;
            end else if (match_in) begin
               verdict_in            = 1'b1;
               result.status         = ST_FOUND;
               result.content_offset = e_pos + BLEN_W'(1);
               result.content_length = clen;
            end else if (spare < BLEN_W'(MIN_ELEMENT_BYTES)) begin
               verdict_in    = 1'b1;
               result.status = ST_NOTFOUND;
            end else if (clen == '0) begin
               phase_in = PH_TAG;
            end else begin
               skip_in  = clen[BLEN_W-1:0];
               phase_in = PH_SKIP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TAG;
         left_ff    <= '0;
         pos_ff     <= '0;
         acc_ff     <= '0;
         pend_ff    <= '0;
         skip_ff    <= '0;
         match_ff   <= 1'b0;
         verdict_ff <= 1'b1;
      end else if (step) begin
         phase_ff   <= phase_in;
         left_ff    <= left_in;
         pos_ff     <= pos_in;
         acc_ff     <= acc_in;
         pend_ff    <= pend_in;
         skip_ff    <= skip_in;
         match_ff   <= match_in;
         verdict_ff <= verdict_in;
      end
   end

endmodule

/* rtl/core/dts_out_reg.sv */
// Result register with valid/ready handshake toward the receiver.
module dts_out_reg
   import dts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  result,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic        can_load,
   output result_type  held
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign can_load  = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign held      = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

/* rtl/core/der_tag_scanner.sv */
// DER tag scanner: finds one top-level element of a DER buffer in a byte stream.
//
// Bytes enter on the req_ channel, one item per byte, in buffer order. The
// item that carries req_first_byte high starts a new buffer and brings its
// total length on req_buffer_length. Every byte gives exactly one item on the
// rsp_ channel: status scanning while the walk goes on, then one verdict
// (found, not found or malformed) on the byte that decides it, then scanning
// with zero fields until the next first byte.
// The byte lands in the input register when it is accepted, and the element
// walk then loads the result register, which drives rsp_valid. The block takes
// one byte per cycle while the receiver keeps up; a receiver stall holds the
// flow. The parser updates its whole scan state once for each byte it takes.
// The csr_ channel writes target_tag; it is always ready and should be used
// only while no byte is in flight.
// After reset the block is idle and ignores bytes until a first byte arrives;
// target_tag resets to zero. When the receiver stalls, the result register
// and the input register hold their items and req_ready falls once both are
// full; nothing is dropped.
module der_tag_scanner
   import dts_pkg::*;
#(
   parameter int unsigned MAX_BUFFER_BYTES = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_first_byte,
   input  logic [BLEN_W-1:0] req_buffer_length,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [BLEN_W-1:0] rsp_content_offset,
   output logic [CLEN_W-1:0] rsp_content_length,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        byte_ff;
   logic              first_ff;
   logic [BLEN_W-1:0] blen_ff;
   logic [7:0]        target_ff;
   logic              advance;
   logic              can_load;
   result_type        result;
   result_type        held;

   assign csr_ready   = 1'b1;
   assign advance     = in_valid_ff && can_load;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         target_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid) begin
            target_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff  <= req_data_byte;
         first_ff <= req_first_byte;
         blen_ff  <= req_buffer_length;
      end
   end

   dts_parser #(
      .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .target_tag   (target_ff),
      .data_byte    (byte_ff),
      .first_byte   (first_ff),
      .buffer_length(blen_ff),
      .result       (result)
   );

   dts_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .can_load (can_load),
      .held     (held)
   );

   assign rsp_status         = held.status;
   assign rsp_content_offset = held.content_offset;
   assign rsp_content_length = held.content_length;

endmodule
